### src/quadratic_phase_chirp_mixer_macros.svh
// Assertion helpers used by the mixer's top level.
`ifndef QUADRATIC_PHASE_CHIRP_MIXER_MACROS_SVH
`define QUADRATIC_PHASE_CHIRP_MIXER_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define QPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define QPCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/qpcm_pkg.sv
package qpcm_pkg;

  localparam int PHASE_BITS   = 48;
  localparam int SAMPLE_BITS  = 16;
  localparam int SINCOS_BITS  = 18;
  localparam int ANG_BITS     = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int STEP_BITS    = 5;
  localparam int PROD_BITS    = SAMPLE_BITS + SINCOS_BITS;
  localparam int ACC_BITS     = PROD_BITS + 2;
  localparam int RND_SH       = SINCOS_BITS - 2;
  localparam int CORDIC_SH    = 32 - SINCOS_BITS;
  localparam int COEFF_BITS   = 48;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_COEFF  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
    logic                          en;
    logic [ANG_BITS-1:0]           angle;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Arctangent of 2^-i in turns, scaled 2^32.
  function automatic logic [29:0] atan_turn(input logic [STEP_BITS-1:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0:  r = 30'h20000000;
        5'd1:  r = 30'h12E4051E;
        5'd2:  r = 30'h09FB385B;
        5'd3:  r = 30'h051111D4;
        5'd4:  r = 30'h028B0D43;
        5'd5:  r = 30'h0145D7E1;
        5'd6:  r = 30'h00A2F61E;
        5'd7:  r = 30'h00517C55;
        5'd8:  r = 30'h0028BE53;
        5'd9:  r = 30'h00145F2F;
        5'd10: r = 30'h000A2F98;
        5'd11: r = 30'h000517CC;
        5'd12: r = 30'h00028BE6;
        5'd13: r = 30'h000145F3;
        5'd14: r = 30'h0000A2FA;
        5'd15: r = 30'h0000517D;
        5'd16: r = 30'h000028BE;
        5'd17: r = 30'h0000145F;
        5'd18: r = 30'h00000A30;
        5'd19: r = 30'h00000518;
        5'd20: r = 30'h0000028C;
        5'd21: r = 30'h00000146;
        5'd22: r = 30'h000000A3;
        5'd23: r = 30'h00000051;
        5'd24: r = 30'h00000029;
        5'd25: r = 30'h00000014;
        5'd26: r = 30'h0000000A;
        5'd27: r = 30'h00000005;
        5'd28: r = 30'h00000003;
        5'd29: r = 30'h00000001;
        default: r = 30'h0;
      endcase
      return r;
    end
  endfunction

  // Rounds half up by 2^RND_SH and saturates to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_BITS-1:0] a
  );
    logic signed [ACC_BITS-1:0] t;
    begin
      t = (a + (ACC_BITS'(1) <<< (RND_SH - 1))) >>> RND_SH;
      if (t > ACC_BITS'(32767)) begin
        return 16'sh7FFF;
      end else if (t < -ACC_BITS'(32768)) begin
        return 16'sh8000;
      end
      return t[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

### src/qpcm_if.sv
interface qpcm_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       sample_re;
  logic signed [15:0]       sample_im;
  logic                     last_sample;

  modport source (output valid, sample_re, sample_im, last_sample, input ready);
  modport sink   (input valid, sample_re, sample_im, last_sample, output ready);
endinterface

interface qpcm_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       out_re;
  logic signed [15:0]       out_im;
  logic                     last_out;

  modport source (output valid, out_re, out_im, last_out, input ready);
  modport sink   (input valid, out_re, out_im, last_out, output ready);
endinterface

### src/qpcm_front.sv
module qpcm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  qpcm_in_if.sink                             in_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [qpcm_pkg::COEFF_BITS-1:0]     cfg_data_i,
  input  qpcm_pkg::q_stat_t                   q_stat_i,
  output logic                                push_o,
  output qpcm_pkg::item_t                     push_item_o
);
  import qpcm_pkg::*;

  logic                  en_q;
  logic [PHASE_BITS-1:0] coeff_q;
  logic [PHASE_BITS-1:0] frac_q, frac_d, step_q, step_d;
  logic                  start_q;
  logic [PHASE_BITS-1:0] frac_cur, step_cur;

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && in_i.ready;

  // A new block starts from phase zero with the coefficient as it stands.
  assign frac_cur = start_q ? '0 : frac_q;
  assign step_cur = start_q ? coeff_q : step_q;
  assign frac_d   = frac_cur + step_cur;
  assign step_d   = step_cur + (coeff_q << 1);

  always_comb begin
    push_item_o.re    = in_i.sample_re;
    push_item_o.im    = in_i.sample_im;
    push_item_o.last  = in_i.last_sample;
    push_item_o.en    = en_q;
    push_item_o.angle = frac_cur[PHASE_BITS-1 -: ANG_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      coeff_q <= '0;
      frac_q  <= '0;
      step_q  <= '0;
      start_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ENABLE) begin
          en_q <= cfg_data_i[0];
        end else begin
          coeff_q <= cfg_data_i;
        end
      end
      if (push_o) begin
        frac_q  <= frac_d;
        step_q  <= step_d;
        start_q <= in_i.last_sample;
      end
    end
  end

endmodule

### src/qpcm_fifo.sv
module qpcm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qpcm_pkg::item_t   push_item_i,
  input  logic              pop_i,
  output qpcm_pkg::item_t   head_o,
  output qpcm_pkg::q_stat_t stat_o
);
  import qpcm_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### src/qpcm_back.sv
module qpcm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qpcm_pkg::item_t   item_i,
  input  qpcm_pkg::q_stat_t stat_i,
  output logic              pop_o,
  qpcm_out_if.source        out_o
);
  import qpcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ROT  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e                        st_q;
  logic signed [SAMPLE_BITS-1:0] re_q, im_q;
  logic                          last_q, en_q, flip_q;
  logic signed [CW-1:0]          x_q, y_q, z_q;
  logic [STEP_BITS-1:0]          i_q;
  logic signed [SINCOS_BITS-1:0] c_q, s_q;
  logic signed [PROD_BITS-1:0]   p_rc_q, p_is_q, p_rs_q, p_ic_q;
  logic                          ov_q;
  logic signed [SAMPLE_BITS-1:0] ore_q, oim_q;
  logic                          olast_q;

  logic signed [CW-1:0] z0, atan_s, xs, ys, xf, yf, xr, yr;
  logic signed [ACC_BITS-1:0] acc_re, acc_im;
  logic                 load;

  assign pop_o = (st_q == ST_IDLE) && !stat_i.empty;
  assign load  = (st_q == ST_DONE) && (!ov_q || out_o.ready);

  assign z0     = CW'($signed(item_i.angle));
  assign atan_s = $signed({4'b0, atan_turn(i_q)});
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign xf     = flip_q ? -x_q : x_q;
  assign yf     = flip_q ? -y_q : y_q;
  assign xr     = (xf + (CW'(1) <<< (CORDIC_SH - 1))) >>> CORDIC_SH;
  assign yr     = (yf + (CW'(1) <<< (CORDIC_SH - 1))) >>> CORDIC_SH;
  assign acc_re = ACC_BITS'(p_rc_q) - ACC_BITS'(p_is_q);
  assign acc_im = ACC_BITS'(p_rs_q) + ACC_BITS'(p_ic_q);

  assign out_o.valid    = ov_q;
  assign out_o.out_re   = ore_q;
  assign out_o.out_im   = oim_q;
  assign out_o.last_out = olast_q;

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        re_q   <= item_i.re;
        im_q   <= item_i.im;
        last_q <= item_i.last;
        en_q   <= item_i.en;
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        i_q    <= '0;
        // Fold the angle into the right half plane; the result is negated later.
        if (z0 > CW'(34'sh40000000)) begin
          z_q    <= z0 - CW'(34'sh80000000);
          flip_q <= 1'b1;
        end else if (z0 < -CW'(34'sh40000000)) begin
          z_q    <= z0 + CW'(34'sh80000000);
          flip_q <= 1'b1;
        end else begin
          z_q    <= z0;
          flip_q <= 1'b0;
        end
      end
      ST_ROT: begin
        if (!z_q[CW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_s;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_s;
        end
        i_q <= i_q + 1'b1;
      end
      ST_RND: begin
        c_q <= xr[SINCOS_BITS-1:0];
        s_q <= yr[SINCOS_BITS-1:0];
      end
      ST_MUL: begin
        p_rc_q <= re_q * c_q;
        p_is_q <= im_q * s_q;
        p_rs_q <= re_q * s_q;
        p_ic_q <= im_q * c_q;
      end
      default: begin
      end
    endcase
    if (load) begin
      ore_q   <= en_q ? round_sat(acc_re) : re_q;
      oim_q   <= en_q ? round_sat(acc_im) : im_q;
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: if (pop_o) st_q <= item_i.en ? ST_ROT : ST_DONE;
        ST_ROT:  if (i_q == STEP_BITS'(CORDIC_STEPS - 1)) st_q <= ST_RND;
        ST_RND:  st_q <= ST_MUL;
        ST_MUL:  st_q <= ST_DONE;
        ST_DONE: if (load) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/quadratic_phase_chirp_mixer.sv
// Channel   Direction  Request payload
// in_i      sink       sample_re, sample_im, last_sample
// out_o     source     out_re, out_im, last_out
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// A rotated sample goes from the head of the queue through 30 iterations of one
// shared CORDIC stage, then rounding, multiply and the output register; a bypassed
// sample goes straight from the head of the queue to the output register.
// The phase front end and a two-entry queue accept samples while the back end
// works. Reset is asynchronous and clears the phase, the queue and the output valid.
`include "quadratic_phase_chirp_mixer_macros.svh"

module quadratic_phase_chirp_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  qpcm_in_if.sink                         in_i,
  qpcm_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [qpcm_pkg::COEFF_BITS-1:0] cfg_data_i
);
  import qpcm_pkg::*;

  item_t   push_item, head;
  q_stat_t q_stat;
  logic    push, pop;

  qpcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  qpcm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  qpcm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  `QPCM_ASSERT(a_no_overflow, push |-> !q_stat.full, "request pushed into a full queue")
  `QPCM_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "request popped from an empty queue")
  `QPCM_ASSERT(a_stat_sane, !(q_stat.full && q_stat.empty), "queue full and empty")
  `QPCM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_o.valid, "result valid after reset")

endmodule
